FILE: sv/dpd_pkg.sv
package dpd_pkg;

   localparam int unsigned MaxResults = 4;

   localparam logic [7:0] ChStart = 8'h24;
   localparam logic [7:0] ChEnd   = 8'h23;
   localparam logic [7:0] ChSep   = 8'h3A;
   localparam logic [7:0] ChAck   = 8'h2B;
   localparam logic [7:0] ChNak   = 8'h2D;

   localparam logic [1:0] PhHunt = 2'd0;
   localparam logic [1:0] PhData = 2'd1;
   localparam logic [1:0] PhDig1 = 2'd2;
   localparam logic [1:0] PhDig2 = 2'd3;

   localparam logic [2:0] KindPayload = 3'd0;
   localparam logic [2:0] KindXmit    = 3'd1;
   localparam logic [2:0] KindAccept  = 3'd2;
   localparam logic [2:0] KindBadSum  = 3'd3;
   localparam logic [2:0] KindAbandon = 3'd4;

   localparam logic [15:0] MaxLenReset = 16'd8095;

   typedef struct packed {
      logic [1:0]       phase;
      logic [7:0]       running_sum;
      logic [7:0]       high_digit_sum;
      logic [15:0]      byte_count;
      logic [2:0][7:0]  first_bytes;
   } state_type;

   typedef struct packed {
      logic [2:0]       cnt;
      logic [3:0][2:0]  kind;
      logic [3:0][7:0]  data;
   } bundle_type;

   function automatic logic [7:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else if (c >= 8'h30 && c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = 8'hFF;
      end
      return v;
   endfunction

endpackage

FILE: sv/debug_packet_deframer.sv
// the first result beat is valid in the cycle after the input beat is taken
// throughput: one input beat per cycle while rsp_ready is high and each beat
// yields one result at most; a byte with more holds input till its last is taken
// reset (synchronous, active high): hunting for start mark, sum and count zero,
// result queue empty, max_len_ff back to 8095
module debug_packet_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   dpd_pkg::state_type  state_ff;
   dpd_pkg::state_type  state_in;
   dpd_pkg::bundle_type bundle;
   logic [15:0]         max_len_ff;
   logic [2:0]          cnt_ff;
   logic [3:0][2:0]     kind_ff;
   logic [3:0][7:0]     data_ff;
   logic                req_take;
   logic                rsp_take;

   dpd_step u_step (
      .state      (state_ff),
      .max_len    (max_len_ff),
      .rx_byte    (req_rx_byte),
      .state_next (state_in),
      .bundle     (bundle)
   );

   assign rsp_valid     = (cnt_ff != 3'd0);
   assign rsp_kind      = kind_ff[0];
   assign rsp_data_byte = data_ff[0];
   assign rsp_last      = (cnt_ff == 3'd1);
   assign rsp_take      = rsp_valid && rsp_ready;
   assign req_ready     = (cnt_ff == 3'd0) || (rsp_last && rsp_ready);
   assign req_take      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= dpd_pkg::MaxLenReset;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= dpd_pkg::PhHunt;
         state_ff.running_sum    <= 8'd0;
         state_ff.high_digit_sum <= 8'd0;
         state_ff.byte_count     <= 16'd0;
      end else if (req_take) begin
         state_ff <= state_in;
      end
   end

   // result queue, head at entry 0
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 3'd0;
      end else if (req_take) begin
         cnt_ff <= bundle.cnt;
      end else if (rsp_take) begin
         cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff <= bundle.kind;
         data_ff <= bundle.data;
      end else if (rsp_take) begin
         kind_ff <= {3'd0, kind_ff[3:1]};
         data_ff <= {8'd0, data_ff[3:1]};
      end
   end

endmodule

FILE: sv/dpd_step.sv
module dpd_step (
   input  dpd_pkg::state_type  state,
   input  logic [15:0]         max_len,
   input  logic [7:0]          rx_byte,
   output dpd_pkg::state_type  state_next,
   output dpd_pkg::bundle_type bundle
);

   logic [7:0]  hex;
   logic [15:0] count_inc;
   logic [7:0]  given;
   logic        seq;
   logic        len_zero;

   assign hex       = dpd_pkg::hex_value(rx_byte);
   assign count_inc = (state.byte_count != 16'hFFFF) ? state.byte_count + 16'd1
                                                     : state.byte_count;
   assign given     = state.high_digit_sum + hex;
   assign seq       = (state.byte_count >= 16'd3) && (state.first_bytes[2] == dpd_pkg::ChSep);
   assign len_zero  = (max_len == 16'd0);

   always_comb begin
      state_next = state;
      bundle     = '0;
      case (state.phase)
         dpd_pkg::PhHunt: begin
            if (rx_byte == dpd_pkg::ChStart) begin
               state_next.running_sum = 8'd0;
               state_next.byte_count  = 16'd0;
               if (len_zero) begin
                  bundle.cnt     = 3'd1;
                  bundle.kind[0] = dpd_pkg::KindAbandon;
               end else begin
                  state_next.phase = dpd_pkg::PhData;
               end
            end
         end
         dpd_pkg::PhData: begin
            if (rx_byte == dpd_pkg::ChStart) begin
               // restart inside a packet
               bundle.cnt             = 3'd1;
               bundle.kind[0]         = dpd_pkg::KindAbandon;
               state_next.running_sum = 8'd0;
               state_next.byte_count  = 16'd0;
               state_next.phase       = len_zero ? dpd_pkg::PhHunt : dpd_pkg::PhData;
            end else if (rx_byte == dpd_pkg::ChEnd) begin
               state_next.phase = dpd_pkg::PhDig1;
            end else begin
               bundle.cnt             = 3'd1;
               bundle.kind[0]         = dpd_pkg::KindPayload;
               bundle.data[0]         = rx_byte;
               state_next.running_sum = state.running_sum + rx_byte;
               if (state.byte_count < 16'd3) begin
                  state_next.first_bytes[state.byte_count[1:0]] = rx_byte;
               end
               state_next.byte_count = count_inc;
               if (count_inc >= max_len) begin
                  bundle.cnt       = 3'd2;
                  bundle.kind[1]   = dpd_pkg::KindAbandon;
                  state_next.phase = dpd_pkg::PhHunt;
               end
            end
         end
         dpd_pkg::PhDig1: begin
            state_next.high_digit_sum = {hex[3:0], 4'h0};
            state_next.phase          = dpd_pkg::PhDig2;
         end
         default: begin
            state_next.phase = dpd_pkg::PhHunt;
            bundle.kind[0]   = dpd_pkg::KindXmit;
            if (given == state.running_sum) begin
               bundle.data[0] = dpd_pkg::ChAck;
               if (seq) begin
                  bundle.cnt     = 3'd4;
                  bundle.kind[1] = dpd_pkg::KindXmit;
                  bundle.data[1] = state.first_bytes[0];
                  bundle.kind[2] = dpd_pkg::KindXmit;
                  bundle.data[2] = state.first_bytes[1];
                  bundle.kind[3] = dpd_pkg::KindAccept;
                  bundle.data[3] = 8'd1;
               end else begin
                  bundle.cnt     = 3'd2;
                  bundle.kind[1] = dpd_pkg::KindAccept;
               end
            end else begin
               bundle.cnt     = 3'd2;
               bundle.data[0] = dpd_pkg::ChNak;
               bundle.kind[1] = dpd_pkg::KindBadSum;
            end
         end
      endcase
   end

endmodule

FILE: sv/dpd_checker.sv
module dpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_data_byte) && $stable(rsp_last))
      else $error("stalled result beat changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result queue not empty after reset");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_verdict_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dpd_pkg::KindAccept || rsp_kind == dpd_pkg::KindBadSum
         || rsp_kind == dpd_pkg::KindAbandon) |-> rsp_last)
      else $error("packet verdict not the final beat");

   a_badsum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == dpd_pkg::KindBadSum || rsp_kind == dpd_pkg::KindAbandon)
         |-> rsp_data_byte == 8'd0)
      else $error("failure verdict carries data");

endmodule

bind debug_packet_deframer dpd_checker u_dpd_checker (.*);
